@@ src/rhl_pkg.sv @@
// Package for the rainbow HSV LED grid core.
// Holds grid, colour and fixed-point constants, sector codes and the item types.
// No dependencies.
`default_nettype none

package rhl_pkg;

    localparam int GRID_SIZE   = 8;
    localparam int GRID_BITS   = 3;
    localparam int PIX_COUNT   = GRID_SIZE * GRID_SIZE;
    localparam int CNT_BITS    = 2 * GRID_BITS;
    localparam int CHANNEL_MAX = 63;
    localparam int CHAN_BITS   = 6;
    localparam int PHASE_BITS  = 16;
    localparam int BRIGHT_BITS = 7;
    localparam int SAT_BITS    = 17;
    localparam int H6_BITS     = PHASE_BITS + 3;
    localparam int FRAC_BITS   = 16;
    localparam int FACT_BITS   = 33;
    localparam int K_BITS      = 13;
    localparam int PROD_BITS   = K_BITS + FACT_BITS;
    localparam int Q_BITS      = PROD_BITS - 32;
    localparam int DIV_BITS    = 13;
    localparam int DIV_PROD    = Q_BITS + DIV_BITS;
    localparam int DIV_SHIFT   = 19;

    localparam logic [BRIGHT_BITS-1:0] BRIGHT_MAX = BRIGHT_BITS'(100);
    localparam logic [SAT_BITS-1:0]    Q16_ONE    = SAT_BITS'(65536);
    localparam logic [SAT_BITS-1:0]    SAT_RESET  = SAT_BITS'(52429);
    localparam logic [FACT_BITS-1:0]   ONE32      = FACT_BITS'(64'h1_0000_0000);
    localparam logic [K_BITS-1:0]      CHAN_MAX_K = K_BITS'(CHANNEL_MAX);
    localparam logic [DIV_BITS-1:0]    DIV100_MUL = DIV_BITS'(5243);
    localparam logic [CNT_BITS-1:0]    CNT_LAST   = CNT_BITS'(PIX_COUNT - 1);
    localparam logic [GRID_BITS-1:0]   GRID_LAST  = GRID_BITS'(GRID_SIZE - 1);

    localparam int                     ADDR_BITS  = 3;
    localparam logic                   REG_SAT    = 1'b0;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    typedef struct packed {
        logic [GRID_BITS-1:0] x;
        logic [GRID_BITS-1:0] y;
        logic                 last;
    } rhl_tag_t;

    typedef struct packed {
        logic                   valid;
        rhl_tag_t               tag;
        logic [PHASE_BITS-1:0]  phase;
        logic [BRIGHT_BITS-1:0] bright;
    } rhl_req_t;

    typedef struct packed {
        logic                 valid;
        rhl_tag_t             tag;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } rhl_pix_t;

endpackage

`default_nettype wire

@@ src/rhl_pixel_pipe.sv @@
// Four-stage pixel colour pipeline: hue split, saturation product,
// channel scaling and divide by one hundred. Depends on rhl_pkg.
`default_nettype none

module rhl_pixel_pipe (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic [rhl_pkg::SAT_BITS-1:0]   sat,
    input  wire rhl_pkg::rhl_req_t              req,
    output rhl_pkg::rhl_pix_t                   pix
);
    import rhl_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    rhl_tag_t               tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [2:0]             sec1_reg, sec2_reg;
    logic [FRAC_BITS-1:0]   f1_reg, f2_reg;
    logic [K_BITS-1:0]      k1_reg, k2_reg;
    logic [FACT_BITS-1:0]   p2_reg;
    logic [Q_BITS-1:0]      qr3_reg, qg3_reg, qb3_reg;
    logic [CHAN_BITS-1:0]   r4_reg, g4_reg, b4_reg;

    logic [PHASE_BITS-1:0]  hue;
    logic [H6_BITS-1:0]     h6;
    logic [K_BITS-1:0]      k_next;
    logic [SAT_BITS-1:0]    m;
    logic [2*SAT_BITS-1:0]  p_full;
    logic [FACT_BITS-1:0]   ones, fq, fr, fg, fb;
    logic [PROD_BITS-1:0]   nr, ng, nb;
    logic [DIV_PROD-1:0]    dr, dg, db;

    // stage 1: hue, sector and fraction
    always_comb
    begin
        hue    = req.phase + {req.tag.x + req.tag.y, {(PHASE_BITS-GRID_BITS){1'b0}}};
        h6     = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
        k_next = K_BITS'(req.bright) * CHAN_MAX_K;
    end

    // stage 2: saturation product
    always_comb
    begin
        m      = (sec1_reg == SEC_1) ? (Q16_ONE - {1'b0, f1_reg}) : {1'b0, f1_reg};
        p_full = (2*SAT_BITS)'(sat) * (2*SAT_BITS)'(m);
    end

    // stage 3: factor selection and scaling
    always_comb
    begin
        ones = {(Q16_ONE - sat), 16'h0000};
        fq   = {1'b0, f2_reg, 16'h0000};
        case (sec2_reg)
            SEC_0:
            begin
                fr = ONE32;        fg = ones;         fb = ONE32 - p2_reg;
            end
            SEC_1:
            begin
                fr = ONE32 - p2_reg; fg = ONE32;      fb = ones;
            end
            SEC_2:
            begin
                fr = ones;         fg = ONE32;        fb = fq;
            end
            SEC_3:
            begin
                fr = ONE32 - p2_reg; fg = ones;       fb = ONE32;
            end
            SEC_4:
            begin
                fr = ones;         fg = fq;           fb = ONE32;
            end
            default:
            begin
                fr = ONE32;        fg = p2_reg;       fb = ONE32;
            end
        endcase
        nr = PROD_BITS'(k2_reg) * PROD_BITS'(fr);
        ng = PROD_BITS'(k2_reg) * PROD_BITS'(fg);
        nb = PROD_BITS'(k2_reg) * PROD_BITS'(fb);
    end

    // stage 4: divide by one hundred
    always_comb
    begin
        dr = DIV_PROD'(qr3_reg) * DIV_PROD'(DIV100_MUL);
        dg = DIV_PROD'(qg3_reg) * DIV_PROD'(DIV100_MUL);
        db = DIV_PROD'(qb3_reg) * DIV_PROD'(DIV100_MUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg <= req.tag;
            sec1_reg <= h6[H6_BITS-1:PHASE_BITS];
            f1_reg   <= h6[PHASE_BITS-1:0];
            k1_reg   <= k_next;

            tag2_reg <= tag1_reg;
            sec2_reg <= sec1_reg;
            f2_reg   <= f1_reg;
            k2_reg   <= k1_reg;
            p2_reg   <= p_full[FACT_BITS-1:0];

            tag3_reg <= tag2_reg;
            qr3_reg  <= nr[PROD_BITS-1:32];
            qg3_reg  <= ng[PROD_BITS-1:32];
            qb3_reg  <= nb[PROD_BITS-1:32];

            tag4_reg <= tag3_reg;
            r4_reg   <= dr[DIV_SHIFT+CHAN_BITS-1:DIV_SHIFT];
            g4_reg   <= dg[DIV_SHIFT+CHAN_BITS-1:DIV_SHIFT];
            b4_reg   <= db[DIV_SHIFT+CHAN_BITS-1:DIV_SHIFT];
        end
    end

    assign pix.valid = v4_reg;
    assign pix.tag   = tag4_reg;
    assign pix.red   = r4_reg;
    assign pix.green = g4_reg;
    assign pix.blue  = b4_reg;

endmodule

`default_nettype wire

@@ src/rainbow_hsv_led_grid_core.sv @@
// Rainbow HSV LED grid core: frame request sequencer, saturation register
// and APB port around the pixel pipeline. Depends on rhl_pkg, rhl_pixel_pipe.
//
// Usage:
//   An input item (phase, brightness) requests one frame. The core emits
//   64 pixel items, row by row, each with col_x, row_y and six-bit red,
//   green and blue levels; last_pixel marks the 64th.
//   Throughput: one pixel per cycle while out_stall does not freeze the
//   pipeline, paced by the pixel counter of the frame sequencer. The next
//   request is taken in the cycle the current frame's last pixel enters the
//   pipeline. A request is loaded into the sequencer at the edge that
//   accepts it; its pixels then pass four pipeline stages (hue split,
//   saturation product, channel scaling, divide by one hundred) before
//   out_valid rises for them.
//   out_stall against a waiting pixel freezes the whole pipeline and the
//   sequencer; nothing is dropped or repeated, and in_stall rises while a
//   frame is in progress.
//   Reset empties the pipeline and loads saturation with 52429 (about 0.8).
//   Write saturation over APB only while no frame is in flight.
`default_nettype none

module rainbow_hsv_led_grid_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rhl_pkg::PHASE_BITS-1:0]    phase,
    input  wire logic [rhl_pkg::BRIGHT_BITS-1:0]   brightness,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rhl_pkg::GRID_BITS-1:0]          col_x,
    output logic [rhl_pkg::GRID_BITS-1:0]          row_y,
    output logic [rhl_pkg::CHAN_BITS-1:0]          red,
    output logic [rhl_pkg::CHAN_BITS-1:0]          green,
    output logic [rhl_pkg::CHAN_BITS-1:0]          blue,
    output logic                                   last_pixel,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rhl_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import rhl_pkg::*;

    logic                   busy_reg, busy_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [BRIGHT_BITS-1:0] bright_reg;
    logic [SAT_BITS-1:0]    sat_reg;
    logic [SAT_BITS-1:0]    sat_clamped;
    logic                   en;
    logic                   in_take;
    logic                   frame_end;
    logic                   cfg_wr;
    rhl_req_t               req;
    rhl_pix_t               pix;

    assign en        = !(pix.valid && out_stall);
    assign frame_end = busy_reg && en && (cnt_reg == CNT_LAST);
    assign in_stall  = busy_reg && !frame_end;
    assign in_take   = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && en)
        begin
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
        if (in_take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold the frame request, brightness clamped to one hundred
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            phase_reg  <= phase;
            bright_reg <= (brightness > BRIGHT_MAX) ? BRIGHT_MAX : brightness;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_BITS-1] == REG_SAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= SAT_RESET;
        end
        else if (cfg_wr)
        begin
            sat_reg <= pwdata[SAT_BITS-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr[ADDR_BITS-1] == REG_SAT) ? {{(32-SAT_BITS){1'b0}}, sat_reg}
                                                         : 32'h0000_0000;
    assign sat_clamped = (sat_reg > Q16_ONE) ? Q16_ONE : sat_reg;

    assign req.valid    = busy_reg;
    assign req.tag.x    = cnt_reg[GRID_BITS-1:0];
    assign req.tag.y    = cnt_reg[CNT_BITS-1:GRID_BITS];
    assign req.tag.last = (cnt_reg == CNT_LAST);
    assign req.phase    = phase_reg;
    assign req.bright   = bright_reg;

    rhl_pixel_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .sat   (sat_clamped),
        .req   (req),
        .pix   (pix)
    );

    assign out_valid  = pix.valid;
    assign col_x      = pix.tag.x;
    assign row_y      = pix.tag.y;
    assign last_pixel = pix.tag.last;
    assign red        = pix.red;
    assign green      = pix.green;
    assign blue       = pix.blue;

    a_take_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && busy_reg) |-> (en && cnt_reg == CNT_LAST))
        else $error("request taken in the middle of a frame");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_pixel) |-> (col_x == GRID_LAST && row_y == GRID_LAST))
        else $error("last pixel away from the final cell");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && busy_reg) |=> $stable(cnt_reg))
        else $error("sequencer advanced while the output stalled");

    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (busy_reg && cnt_reg == '0))
        else $error("frame did not start at the first cell");

endmodule

`default_nettype wire

@@ tb/sv/rhl_checker.sv @@
// Checker for the rainbow HSV LED grid core: watches the request, pixel and
// register channels, predicts every pixel of each frame and compares them.
// Depends on rhl_pkg.
module rhl_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [rhl_pkg::PHASE_BITS-1:0]  phase,
    input  wire logic [rhl_pkg::BRIGHT_BITS-1:0] brightness,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [rhl_pkg::GRID_BITS-1:0]   col_x,
    input  wire logic [rhl_pkg::GRID_BITS-1:0]   row_y,
    input  wire logic [rhl_pkg::CHAN_BITS-1:0]   red,
    input  wire logic [rhl_pkg::CHAN_BITS-1:0]   green,
    input  wire logic [rhl_pkg::CHAN_BITS-1:0]   blue,
    input  wire logic                            last_pixel,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rhl_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    input  wire logic                            pready,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   pixels_checked,
    output int                                   frames_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    import rhl_pkg::*;

    typedef struct packed {
        logic [GRID_BITS-1:0] x;
        logic [GRID_BITS-1:0] y;
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
        logic                 last;
    } pixel_t;

    pixel_t              pixel_q[$];
    logic [SAT_BITS-1:0] sat_reg;
    int                  n_err;
    int                  n_pix;
    int                  n_frames;

    function automatic logic [CHAN_BITS-1:0] scale_level(logic [BRIGHT_BITS-1:0] br,
                                                         logic [FACT_BITS-1:0] factor);
        logic [63:0] num;
        num = 64'(br) * 64'(CHANNEL_MAX) * 64'(factor);
        return CHAN_BITS'(num / (64'd100 << 32));
    endfunction

    function automatic void predict_frame(logic [PHASE_BITS-1:0] ph,
                                          logic [BRIGHT_BITS-1:0] br_in);
        logic [BRIGHT_BITS-1:0] br;
        logic [SAT_BITS-1:0]    s;
        logic [PHASE_BITS-1:0]  hue;
        logic [H6_BITS-1:0]     h6;
        logic [2:0]             sector;
        logic [FRAC_BITS-1:0]   f;
        logic [FACT_BITS-1:0]   one_minus_s;
        logic [FACT_BITS-1:0]   s_f;
        logic [FACT_BITS-1:0]   f32;
        logic [FACT_BITS-1:0]   fr;
        logic [FACT_BITS-1:0]   fg;
        logic [FACT_BITS-1:0]   fb;
        pixel_t                 px;
        int                     gx;
        int                     gy;
        br = (br_in > BRIGHT_MAX) ? BRIGHT_MAX : br_in;
        s = (sat_reg > Q16_ONE) ? Q16_ONE : sat_reg;
        for (gy = 0; gy < GRID_SIZE; gy++) begin
            for (gx = 0; gx < GRID_SIZE; gx++) begin
                hue = ph + PHASE_BITS'((gx + gy) << (PHASE_BITS - GRID_BITS));
                h6 = H6_BITS'(hue) * H6_BITS'(6);
                sector = h6[H6_BITS-1:PHASE_BITS];
                f = h6[FRAC_BITS-1:0];
                one_minus_s = (FACT_BITS'(Q16_ONE) - FACT_BITS'(s)) << 16;
                s_f = FACT_BITS'(s) * FACT_BITS'(f);
                f32 = FACT_BITS'(f) << 16;
                case (sector)
                    SEC_0:
                    begin
                        fr = ONE32; fg = one_minus_s; fb = ONE32 - s_f;
                    end
                    SEC_1:
                    begin
                        fr = ONE32 - FACT_BITS'(s) * (FACT_BITS'(Q16_ONE) - FACT_BITS'(f));
                        fg = ONE32; fb = one_minus_s;
                    end
                    SEC_2:
                    begin
                        fr = one_minus_s; fg = ONE32; fb = f32;
                    end
                    SEC_3:
                    begin
                        fr = ONE32 - s_f; fg = one_minus_s; fb = ONE32;
                    end
                    SEC_4:
                    begin
                        fr = one_minus_s; fg = f32; fb = ONE32;
                    end
                    default:
                    begin
                        fr = ONE32; fg = s_f; fb = ONE32;
                    end
                endcase
                px.x = GRID_BITS'(gx);
                px.y = GRID_BITS'(gy);
                px.r = scale_level(br, fr);
                px.g = scale_level(br, fg);
                px.b = scale_level(br, fb);
                px.last = (gx == GRID_SIZE - 1) && (gy == GRID_SIZE - 1);
                pixel_q.push_back(px);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            sat_reg = SAT_RESET;
            pixel_q.delete();
            n_err = 0;
            n_pix = 0;
            n_frames = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{col_x, row_y, red, green, blue, last_pixel};
                if (pixel_q.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d r=%0d g=%0d b=%0d last=%0d",
                                 $realtime, got.x, got.y, got.r, got.g, got.b, got.last);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    n_pix++;
                    if (got.x !== want.x || got.y !== want.y || got.r !== want.r ||
                        got.g !== want.g || got.b !== want.b || got.last !== want.last)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"%0t: pixel mismatch, expected x=%0d y=%0d r=%0d g=%0d ",
                                      "b=%0d last=%0d, got x=%0d y=%0d r=%0d g=%0d b=%0d ",
                                      "last=%0d"}, $realtime,
                                     want.x, want.y, want.r, want.g, want.b, want.last,
                                     got.x, got.y, got.r, got.g, got.b, got.last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_frame(phase, brightness);
                n_frames++;
            end
            if (psel && penable && pwrite && pready &&
                paddr[ADDR_BITS-1:2] == REG_SAT)
                sat_reg = pwdata[SAT_BITS-1:0];
        end
        fail_count <= n_err;
        pending <= pixel_q.size();
        pixels_checked <= n_pix;
        frames_taken <= n_frames;
    end

endmodule

@@ tb/sv/tb.sv @@
// Top of the rainbow HSV LED grid testbench: clock, reset, frame requests,
// saturation writes, output stalls, watchdog and verdict.
// Depends on rhl_pkg, rainbow_hsv_led_grid_core and rhl_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhl_pkg::*;

    localparam logic [ADDR_BITS-1:0] SAT_ADDR    = {REG_SAT, 2'b00};
    localparam logic [ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
    localparam int                   WATCHDOG    = 2000;
    localparam int                   ROUNDS      = 8;
    localparam int                   ROUND_ITEMS = 22;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [PHASE_BITS-1:0]  phase;
    logic [BRIGHT_BITS-1:0] brightness;
    logic                   out_valid;
    logic                   out_stall;
    logic [GRID_BITS-1:0]   col_x;
    logic [GRID_BITS-1:0]   row_y;
    logic [CHAN_BITS-1:0]   red;
    logic [CHAN_BITS-1:0]   green;
    logic [CHAN_BITS-1:0]   blue;
    logic                   last_pixel;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;
    int                     pixels_checked;
    int                     frames_taken;
    logic                   idling;
    int                     n_settings;

    rainbow_hsv_led_grid_core u_top (.*);
    rhl_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int  burst;
        logic hold;
        burst = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
                hold = 1'b1;
            end
            else if (idling && $urandom_range(0, 11) == 0)
            begin
                burst = $urandom_range(1, 14) - 1;
                hold = 1'b1;
            end
            else
                hold = 1'b0;
            out_stall <= hold;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no traffic for %0d cycles, %0d pixels outstanding",
                 WATCHDOG, pending);
        $display("FAILURE");
        $finish;
    end

    task automatic send_frame(input logic [PHASE_BITS-1:0] ph,
                              input logic [BRIGHT_BITS-1:0] br);
        int gap;
        gap = (idling && $urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        phase <= ph;
        brightness <= br;
        do @(posedge clk); while (in_stall);
    endtask

    // drop the request and let the last frame leave the pipeline
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == SAT_ADDR)
            n_settings++;
    endtask

    initial
    begin
        logic [PHASE_BITS-1:0]  dir_phase[24];
        logic [BRIGHT_BITS-1:0] dir_bright[24];
        int                     i;
        int                     r;
        logic [31:0]            sat_word;
        dir_phase = '{16'd0, 16'd65535, 16'd0, 16'd10922, 16'd10923, 16'd21845,
                      16'd21846, 16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54612,
                      16'd0, 16'd32767, 16'd54613, 16'd8191, 16'd65535, 16'd12345,
                      16'd5461, 16'd60000, 16'd32768, 16'd49151, 16'd1, 16'd27306};
        dir_bright = '{7'd100, 7'd127, 7'd0, 7'd101, 7'd1, 7'd50,
                       7'd99, 7'd100, 7'd64, 7'd100, 7'd100, 7'd127,
                       7'd100, 7'd100, 7'd100, 7'd100, 7'd63, 7'd127,
                       7'd100, 7'd85, 7'd127, 7'd100, 7'd100, 7'd42};
        rst_n = 1'b0;
        in_valid = 1'b0;
        phase = '0;
        brightness = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idling = 1'b1;
        n_settings = 1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset saturation, then full, then zero, then an oversized write
        for (i = 0; i < 24; i++)
        begin
            if (i == 12 || i == 18 || i == 21)
            begin
                drain();
                if (i == 12)
                    reg_write(SAT_ADDR, 32'd65536);
                else if (i == 18)
                begin
                    reg_write(UNUSED_ADDR, $urandom());
                    reg_write(SAT_ADDR, 32'd0);
                end
                else
                    reg_write(SAT_ADDR, 32'hFFFF_FFFF);
            end
            send_frame(dir_phase[i], dir_bright[i]);
        end

        for (r = 0; r < ROUNDS; r++)
        begin
            drain();
            case ($urandom_range(0, 5))
                0: sat_word = 32'd0;
                1: sat_word = 32'd65536;
                2: sat_word = $urandom();
                default: sat_word = $urandom_range(0, 65536);
            endcase
            if ($urandom_range(0, 2) == 0)
                reg_write(UNUSED_ADDR, $urandom());
            reg_write(SAT_ADDR, sat_word);
            idling = (r < ROUNDS - 1) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < ROUND_ITEMS; i++)
                send_frame(PHASE_BITS'($urandom_range(0, 65535)),
                           BRIGHT_BITS'($urandom_range(0, 127)));
        end

        drain();
        $display("Checked %0d pixels from %0d frame requests over %0d saturation settings,",
                 pixels_checked, frames_taken, n_settings);
        $display("with random stall bursts on both channels and a stall-free final stretch.");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
